FILE: design/bfws_pkg.sv
`timescale 1ns / 1ps

package bfws_pkg;

  // queue geometry
  localparam int unsigned DEPTH    = 16;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 2;

  // request codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_FIND    = 2'd2
  } action_e;

  // response codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_HOLD   = 3'b100
  } state_e;

  // controls broadcast to every cell of the row
  typedef struct packed {
    logic               pop;
    logic               search;
    logic               clear;
    logic [VALUE_W-1:0] data;
  } cell_ctrl_t;

endpackage

FILE: design/bfws_req_if.sv
`timescale 1ns / 1ps

interface bfws_req_if;
  logic                             valid;
  logic                             ready;
  logic [bfws_pkg::ACTION_W-1:0]    action;
  logic [bfws_pkg::VALUE_W-1:0]     item_value;

  modport source (output valid, output action, output item_value, input ready);
  modport sink (input valid, input action, input item_value, output ready);
endinterface

FILE: design/bfws_rsp_if.sv
`timescale 1ns / 1ps

interface bfws_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [bfws_pkg::STATUS_W-1:0]    status;
  logic [bfws_pkg::VALUE_W-1:0]     read_value;

  modport source (output valid, output status, output read_value, input ready);
  modport sink (input valid, input status, input read_value, output ready);
endinterface

FILE: design/bfws_cell.sv
`timescale 1ns / 1ps

module bfws_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfws_pkg::cell_ctrl_t         ctrl_i,
  input  logic                         occupied_i,
  input  logic                         wr_sel_i,
  input  logic [bfws_pkg::VALUE_W-1:0] next_value_i,
  input  logic                         prev_hit_i,
  output logic [bfws_pkg::VALUE_W-1:0] value_o,
  output logic                         hit_o
);

  logic [bfws_pkg::VALUE_W-1:0] value_q, value_d;
  logic                         hit_q, hit_d;

  // slot contents: shift toward the head on a dequeue, load on an enqueue
  always_comb begin
    value_d = value_q;
    if (ctrl_i.pop) begin
      value_d = next_value_i;
    end else if (wr_sel_i) begin
      value_d = ctrl_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // hit flag walks from the head cell toward the tail
  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.clear) begin
      hit_d = 1'b0;
    end else if (ctrl_i.search) begin
      hit_d = prev_hit_i | (occupied_i & (value_q == ctrl_i.data));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

FILE: design/bfws_ctrl.sv
`timescale 1ns / 1ps

module bfws_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bfws_req_if.sink                     req_i,
  bfws_rsp_if.source                   rsp_o,
  input  logic [bfws_pkg::VALUE_W-1:0] head_value_i,
  input  logic                         tail_hit_i,
  output bfws_pkg::cell_ctrl_t         ctrl_o,
  output logic [bfws_pkg::DEPTH-1:0]   occupied_o,
  output logic [bfws_pkg::DEPTH-1:0]   wr_sel_o
);

  bfws_pkg::state_e               state_q, state_d;
  logic [bfws_pkg::CNT_W-1:0]     count_q, count_d;
  logic [bfws_pkg::CNT_W-1:0]     step_q, step_d;
  logic [bfws_pkg::VALUE_W-1:0]   key_q, key_d;
  logic                           out_valid_q, out_valid_d;
  bfws_pkg::status_e              out_status_q, out_status_d;
  logic [bfws_pkg::VALUE_W-1:0]   out_value_q, out_value_d;
  bfws_pkg::status_e              pend_status_q, pend_status_d;
  logic [bfws_pkg::VALUE_W-1:0]   pend_value_q, pend_value_d;

  logic                           accept;
  logic                           out_free;
  logic                           full;
  logic                           empty;
  logic                           push;
  logic                           res_valid;
  bfws_pkg::status_e              res_status;
  logic [bfws_pkg::VALUE_W-1:0]   res_value;

  assign accept   = req_i.valid & req_i.ready;
  assign out_free = ~out_valid_q | rsp_o.ready;
  assign full     = (count_q == bfws_pkg::CNT_W'(bfws_pkg::DEPTH));
  assign empty    = (count_q == '0);

  // request decode and sequencing
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    step_d        = step_q;
    key_d         = key_q;
    push          = 1'b0;
    ctrl_o.pop    = 1'b0;
    ctrl_o.search = 1'b0;
    ctrl_o.clear  = 1'b0;
    ctrl_o.data   = (state_q == bfws_pkg::ST_IDLE) ? req_i.item_value : key_q;
    res_valid     = 1'b0;
    res_status    = bfws_pkg::STS_OK;
    res_value     = '0;

    unique case (state_q)
      bfws_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req_i.action)
            bfws_pkg::ACT_ENQUEUE: begin
              res_valid = 1'b1;
              if (full) begin
                res_status = bfws_pkg::STS_FULL;
              end else begin
                push    = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            bfws_pkg::ACT_DEQUEUE: begin
              res_valid = 1'b1;
              if (empty) begin
                res_status = bfws_pkg::STS_EMPTY;
              end else begin
                ctrl_o.pop = 1'b1;
                res_value  = head_value_i;
                count_d    = count_q - 1'b1;
              end
            end
            bfws_pkg::ACT_FIND: begin
              ctrl_o.clear = 1'b1;
              key_d        = req_i.item_value;
              step_d       = bfws_pkg::CNT_W'(bfws_pkg::DEPTH);
              state_d      = bfws_pkg::ST_SEARCH;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      bfws_pkg::ST_SEARCH: begin
        ctrl_o.search = 1'b1;
        if (step_q == '0) begin
          res_valid  = 1'b1;
          res_status = ((key_q != '0) && tail_hit_i) ? bfws_pkg::STS_OK
                                                      : bfws_pkg::STS_NOT_FOUND;
          state_d    = bfws_pkg::ST_IDLE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      bfws_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = bfws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bfws_pkg::ST_IDLE;
      end
    endcase

    // a finished result waits in the pending register if the output is busy
    if (res_valid && !out_free) begin
      state_d = bfws_pkg::ST_HOLD;
    end
  end

  // output register and pending slot
  always_comb begin
    out_valid_d   = out_valid_q & ~rsp_o.ready;
    out_status_d  = out_status_q;
    out_value_d   = out_value_q;
    pend_status_d = pend_status_q;
    pend_value_d  = pend_value_q;
    if (res_valid) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_status_d = res_status;
        out_value_d  = res_value;
      end else begin
        pend_status_d = res_status;
        pend_value_d  = res_value;
      end
    end else if ((state_q == bfws_pkg::ST_HOLD) && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = pend_status_q;
      out_value_d  = pend_value_q;
    end
  end

  // per-cell occupancy and write select
  always_comb begin
    for (int i = 0; i < bfws_pkg::DEPTH; i++) begin
      occupied_o[i] = (bfws_pkg::CNT_W'(i) < count_q);
      wr_sel_o[i]   = push & (bfws_pkg::CNT_W'(i) == count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfws_pkg::ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q         <= key_d;
    out_status_q  <= out_status_d;
    out_value_q   <= out_value_d;
    pend_status_q <= pend_status_d;
    pend_value_q  <= pend_value_d;
  end

  assign req_i.ready      = (state_q == bfws_pkg::ST_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.read_value = out_value_q;

endmodule

FILE: design/bounded_fifo_with_search.sv
`timescale 1ns / 1ps

// Bounded FIFO of DEPTH 64-bit values with a content search, built as a row
// of cells with the oldest value in the head cell. Enqueue, dequeue and
// unused action codes are finished in the accepting cycle: unless the result
// must wait for the output register, the block is ready for the next request
// in the following cycle. A find holds the block: it clears the match flags in
// the accepting cycle, then the match flag walks the cell row one cell per
// clock from head to tail, and the answer is taken from the tail cell. Each
// request gives one response, held in an output register; if that register
// is still occupied when a result is finished, the result waits in a pending
// slot and no new request is taken until it moves out. A find of zero always reports not found.
module bounded_fifo_with_search (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfws_req_if.sink   req_i,
  bfws_rsp_if.source rsp_o
);

  bfws_pkg::cell_ctrl_t         ctrl;
  logic [bfws_pkg::DEPTH-1:0]   occupied;
  logic [bfws_pkg::DEPTH-1:0]   wr_sel;
  logic [bfws_pkg::VALUE_W-1:0] cell_value [bfws_pkg::DEPTH];
  logic [bfws_pkg::DEPTH-1:0]   cell_hit;

  // sequencer, occupancy and response register
  bfws_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .head_value_i (cell_value[0]),
    .tail_hit_i   (cell_hit[bfws_pkg::DEPTH-1]),
    .ctrl_o       (ctrl),
    .occupied_o   (occupied),
    .wr_sel_o     (wr_sel)
  );

  // row of storage cells, head at index zero
  for (genvar g = 0; g < bfws_pkg::DEPTH; g++) begin : g_cell
    logic [bfws_pkg::VALUE_W-1:0] next_value;
    logic                         prev_hit;

    if (g == bfws_pkg::DEPTH - 1) begin : g_tail
      assign next_value = '0;
    end else begin : g_mid
      assign next_value = cell_value[g+1];
    end

    if (g == 0) begin : g_head
      assign prev_hit = 1'b0;
    end else begin : g_body
      assign prev_hit = cell_hit[g-1];
    end

    bfws_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .occupied_i   (occupied[g]),
      .wr_sel_i     (wr_sel[g]),
      .next_value_i (next_value),
      .prev_hit_i   (prev_hit),
      .value_o      (cell_value[g]),
      .hit_o        (cell_hit[g])
    );
  end

endmodule
